[sv/sorted_value_list_unit_assert.svh]
// ----------------------------------------------------------------------------
// Sorted value list assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_VALUE_LIST_UNIT_ASSERT_SVH
`define SORTED_VALUE_LIST_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SVL_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sorted value list: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SVL_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sorted value list: next-cycle check failed");

// The expression must never be true.
`define SVL_ASSERT_NEVER(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("sorted value list: forbidden condition seen");

`endif

[sv/svl_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted value list package
// Sizes, command and status codes, and the types shared by the cell row.
// ----------------------------------------------------------------------------
package svl_pkg;

   // Number of cells in the row.
   localparam int CAPACITY = 16;
   // Width of the fill count, which must hold CAPACITY itself.
   localparam int CNT_W = $clog2(CAPACITY + 1);
   // Width of an index into the row.
   localparam int IDX_W = $clog2(CAPACITY);
   // Width of the stored values.
   localparam int VAL_W = 32;
   localparam int ENTRY_COUNT_W = 5;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_READ   = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_FULL      = 2'd2
   } status_type;

   typedef enum logic {
      S_IDLE,
      S_READOUT
   } state_type;

   // Operation broadcast to every cell in the same cycle.
   typedef struct packed {
      logic ins_en;
      logic del_en;
      logic rot_en;
   } cell_ctrl_type;

   // What a cell shows to its neighbors.
   typedef struct packed {
      logic signed [VAL_W-1:0] value;
      logic                    valid;
      logic                    ge;
   } cell_link_type;

   // Low bits of the fill count as reported on the result channel.
   function automatic logic [ENTRY_COUNT_W-1:0] to_entry_count(input logic [CNT_W-1:0] c);
      logic [31:0] wide;
      wide = 32'(c);
      return wide[ENTRY_COUNT_W-1:0];
   endfunction

endpackage

[sv/sorted_value_list_unit.sv]
// ----------------------------------------------------------------------------
// Sorted value list unit
// Keeps up to CAPACITY signed values in ascending order in a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one command per transaction: insert, delete one
//   occurrence, or read out. Each result leaves on the rsp_ channel from an
//   output register, with the count and empty flag after the step.
//   Insert, delete and no-op commands finish in the cycle they are accepted:
//   the result is valid in the next cycle, and a new command can be taken every
//   cycle as long as the receiver keeps taking results. Every cell compares
//   the key at once, so the list length does not affect this.
//   A read out of N stored values gives N results, one per cycle while the
//   receiver takes them, by rotating the occupied cells past the head; the
//   next command is taken after the last one has been loaded. An empty store
//   gives one result with is_empty set.
//   A synchronous reset empties the store at once; no clearing pass is run.
//   When the receiver stalls, the result holds in the output register and
//   the block takes no further command until that register is free.
// ----------------------------------------------------------------------------
`include "sorted_value_list_unit_assert.svh"

module sorted_value_list_unit (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_ready,
   input  logic [1:0]                                 req_command,
   input  logic signed [svl_pkg::VAL_W-1:0]           req_value,
   output logic                                       rsp_valid,
   input  logic                                       rsp_ready,
   output logic [1:0]                                 rsp_status,
   output logic [svl_pkg::ENTRY_COUNT_W-1:0]          rsp_entry_count,
   output logic                                       rsp_is_empty,
   output logic signed [svl_pkg::VAL_W-1:0]           rsp_item_value,
   output logic                                       rsp_last
);

   localparam int N = svl_pkg::CAPACITY;

   svl_pkg::state_type                     state_ff, state_in;
   logic [svl_pkg::CNT_W-1:0]              count_ff, count_in;
   logic [svl_pkg::IDX_W-1:0]              idx_ff, idx_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   svl_pkg::status_type                    status_ff, status_in;
   logic [svl_pkg::ENTRY_COUNT_W-1:0]      entry_count_ff, entry_count_in;
   logic                                   is_empty_ff, is_empty_in;
   logic signed [svl_pkg::VAL_W-1:0]       item_value_ff, item_value_in;
   logic                                   last_ff, last_in;

   svl_pkg::cell_ctrl_type                 ctrl;
   svl_pkg::cell_link_type                 links [N];
   svl_pkg::cell_link_type                 lefts [N];
   svl_pkg::cell_link_type                 rights [N];
   logic [N-1:0]                           match_vec;
   logic [N-1:0]                           valid_vec;
   logic                                   out_free;
   logic                                   accept;
   logic                                   found;
   logic                                   full;
   logic                                   final_item;

   // Row of cells, each wired to its neighbors; the ends see fixed links.
   for (genvar i = 0; i < N; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign lefts[i] = '{value: '0, valid: 1'b1, ge: 1'b0};
      end else begin : g_inner_left
         assign lefts[i] = links[i-1];
      end
      if (i == N - 1) begin : g_last
         assign rights[i] = '{value: '0, valid: 1'b0, ge: 1'b1};
      end else begin : g_inner_right
         assign rights[i] = links[i+1];
      end
      assign valid_vec[i] = links[i].valid;

      svl_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .key        (req_value),
         .head_value (links[0].value),
         .left_link  (lefts[i]),
         .right_link (rights[i]),
         .link       (links[i]),
         .match      (match_vec[i])
      );
   end

   // Handshake and summary flags.
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == svl_pkg::S_IDLE) && out_free;
   assign accept     = req_valid && req_ready;
   assign found      = |match_vec;
   assign full       = (count_ff == svl_pkg::CNT_W'(N));
   assign final_item = ((svl_pkg::CNT_W'(idx_ff) + svl_pkg::CNT_W'(1)) == count_ff);

   // Command decode, read-out sequencing and result loading.
   always_comb begin
      logic load;
      load           = 1'b0;
      ctrl           = '0;
      state_in       = state_ff;
      count_in       = count_ff;
      idx_in         = idx_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      status_in      = status_ff;
      entry_count_in = entry_count_ff;
      is_empty_in    = is_empty_ff;
      item_value_in  = item_value_ff;
      last_in        = last_ff;
      status_in      = svl_pkg::STATUS_DONE;

      case (state_ff)
         svl_pkg::S_IDLE: begin
            status_in = status_ff;
            if (accept) begin
               status_in     = svl_pkg::STATUS_DONE;
               item_value_in = '0;
               last_in       = 1'b1;
               case (svl_pkg::cmd_type'(req_command))
                  svl_pkg::CMD_INSERT: begin
                     load = 1'b1;
                     if (full) begin
                        status_in = svl_pkg::STATUS_FULL;
                     end else begin
                        ctrl.ins_en = 1'b1;
                        count_in    = count_ff + svl_pkg::CNT_W'(1);
                     end
                  end
                  svl_pkg::CMD_DELETE: begin
                     load = 1'b1;
                     if (found) begin
                        ctrl.del_en = 1'b1;
                        count_in    = count_ff - svl_pkg::CNT_W'(1);
                     end else begin
                        status_in = svl_pkg::STATUS_NOT_FOUND;
                     end
                  end
                  svl_pkg::CMD_READ: begin
                     if (count_ff == '0) begin
                        load = 1'b1;
                     end else begin
                        state_in = svl_pkg::S_READOUT;
                        idx_in   = '0;
                     end
                  end
                  default: begin
                     load = 1'b1;
                  end
               endcase
            end
         end
         svl_pkg::S_READOUT: begin
            if (out_free) begin
               load          = 1'b1;
               ctrl.rot_en   = 1'b1;
               item_value_in = links[0].value;
               last_in       = final_item;
               idx_in        = idx_ff + svl_pkg::IDX_W'(1);
               if (final_item) begin
                  state_in = svl_pkg::S_IDLE;
               end
            end
         end
         default: begin
            state_in = svl_pkg::S_IDLE;
         end
      endcase

      if (load) begin
         rsp_valid_in   = 1'b1;
         entry_count_in = svl_pkg::to_entry_count(count_in);
         is_empty_in    = (count_in == '0);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= svl_pkg::S_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload register.
   always_ff @(posedge clock) begin
      status_ff      <= status_in;
      entry_count_ff <= entry_count_in;
      is_empty_ff    <= is_empty_in;
      item_value_ff  <= item_value_in;
      last_ff        <= last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_entry_count = entry_count_ff;
   assign rsp_is_empty    = is_empty_ff;
   assign rsp_item_value  = item_value_ff;
   assign rsp_last        = last_ff;

   // The fill count never passes the number of cells.
   `SVL_ASSERT_NEVER(a_count_bound, count_ff > svl_pkg::CNT_W'(N))

   // Occupied cells and the fill count always agree.
   `SVL_ASSERT_IMPLY(a_valid_matches_count, 1'b1, $countones(valid_vec) == 32'(count_ff))

   // An insert into a full store leaves the count alone.
   `SVL_ASSERT_NEXT(a_full_insert_holds,
      accept && (req_command == svl_pkg::CMD_INSERT) && full, $stable(count_ff))

   // Neighboring occupied cells are in ascending order whenever no read out
   // is rotating the row.
   for (genvar j = 0; j < N - 1; j++) begin : g_order_check
      `SVL_ASSERT_IMPLY(a_ascending,
         (state_ff == svl_pkg::S_IDLE) && links[j].valid && links[j+1].valid,
         !(links[j+1].value < links[j].value))
   end

endmodule

[sv/svl_cell.sv]
// ----------------------------------------------------------------------------
// Sorted value list cell
// Holds one value of the ascending row and shifts toward either neighbor.
// ----------------------------------------------------------------------------
module svl_cell (
   input  logic                               clock,
   input  logic                               reset,
   input  svl_pkg::cell_ctrl_type             ctrl,
   input  logic signed [svl_pkg::VAL_W-1:0]   key,
   input  logic signed [svl_pkg::VAL_W-1:0]   head_value,
   input  svl_pkg::cell_link_type             left_link,
   input  svl_pkg::cell_link_type             right_link,
   output svl_pkg::cell_link_type             link,
   output logic                               match
);

   logic signed [svl_pkg::VAL_W-1:0] value_ff, value_in;
   logic                             valid_ff, valid_in;
   logic                             ge;

   // An empty cell counts as greater than any key, so the ge flags form a
   // monotone step along the row and mark the insert or delete position.
   assign ge    = !valid_ff || !(value_ff < key);
   assign match = valid_ff && (value_ff == key);

   assign link.value = value_ff;
   assign link.valid = valid_ff;
   assign link.ge    = ge;

   // Next value: shift right on insert, left on delete, rotate on read out.
   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (ctrl.ins_en) begin
         valid_in = valid_ff || left_link.valid;
         if (left_link.ge) begin
            value_in = left_link.value;
         end else if (ge) begin
            value_in = key;
         end
      end else if (ctrl.del_en) begin
         if (ge) begin
            value_in = right_link.value;
            valid_in = right_link.valid;
         end
      end else if (ctrl.rot_en) begin
         if (valid_ff && right_link.valid) begin
            value_in = right_link.value;
         end else if (valid_ff) begin
            value_in = head_value;
         end
      end
   end

   // Occupancy is control state; the value itself needs no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule
